// ===== hdl/iee_pkg.sv =====
// ----------------------------------------------------------------------------
// iee_pkg: shared definitions for the infix expression evaluator
// Character codes, pending operator codes and operator classes.
// ----------------------------------------------------------------------------
package iee_pkg;

	localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
	localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
	localparam logic [7:0] CH_MUL   = 8'h2A;  // '*'
	localparam logic [7:0] CH_DIV   = 8'h2F;  // '/'
	localparam logic [7:0] CH_ADD   = 8'h2B;  // '+'
	localparam logic [7:0] CH_SUB   = 8'h2D;  // '-'
	localparam logic [7:0] CH_SPACE = 8'h20;  // ' '

	localparam int RESULT_WIDTH = 32;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_MUL   = 2'd1,
		OP_DIV   = 2'd2,
		OP_SPARE = 2'd3
	} pend_op_t;

	typedef enum logic [2:0] {
		KIND_MUL,
		KIND_DIV,
		KIND_ADD,
		KIND_SUB,
		KIND_END
	} kind_t;

endpackage

// ===== hdl/infix_expression_evaluator.sv =====
// ----------------------------------------------------------------------------
// infix_expression_evaluator
// Character-serial integer infix evaluator with * / above + -, one shared
// adder/subtractor driving shift-add multiply and restoring divide.
// ----------------------------------------------------------------------------
// Digits and spaces are taken in ST_IDLE without stalling; any other character
// raises in_stall until the pending product or quotient and the term are folded
// in, and the terminator also waits for the output register to be free. The
// multiply and divide iterate over the single shared adder, one bit a cycle;
// a zero divisor skips the divide.
// arst_n clears all expression state and the output valid asynchronously.
// ----------------------------------------------------------------------------
module infix_expression_evaluator #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         char_code,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] result_value,
	output logic               div_error
);

	localparam int W  = VALUE_WIDTH;
	localparam int CW = $clog2(VALUE_WIDTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLOSE,
		ST_DIVB,
		ST_MUL,
		ST_DIV,
		ST_FIX,
		ST_TERM,
		ST_OUT
	} state_t;

	state_t            state_q;
	iee_pkg::pend_op_t pend_q;
	iee_pkg::kind_t    kind_q;
	logic [W-1:0]      acc_q, term_q, sum_q;
	logic              neg_q, err_q, qneg_q;
	logic [W-1:0]      a_q, b_q, p_q;
	logic [CW-1:0]     cnt_q;
	logic              out_valid_q;
	logic signed [31:0] result_value_q;
	logic              div_error_q;

	// shared adder/subtractor
	logic [W-1:0] alu_a, alu_b;
	logic         alu_sub;
	logic [W:0]   alu_y;
	logic [W-1:0] rem_sh;
	logic         in_acc, last_step;
	logic [W-1:0] digit_next;

	assign rem_sh    = {p_q[W-2:0], b_q[W-1]};
	assign last_step = (cnt_q == CW'(W - 1));

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		case (state_q)
			ST_CLOSE: begin
				alu_b   = term_q;
				alu_sub = term_q[W-1];
			end
			ST_DIVB: begin
				alu_b   = acc_q;
				alu_sub = acc_q[W-1];
			end
			ST_MUL: begin
				alu_a = p_q;
				alu_b = a_q;
			end
			ST_DIV: begin
				alu_a   = rem_sh;
				alu_b   = a_q;
				alu_sub = 1'b1;
			end
			ST_FIX: begin
				alu_b   = b_q;
				alu_sub = qneg_q;
			end
			ST_TERM: begin
				alu_a   = sum_q;
				alu_b   = term_q;
				alu_sub = neg_q;
			end
			default: ;
		endcase
	end

	assign alu_y = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (W+1)'(alu_sub);

	assign digit_next = (acc_q << 3) + (acc_q << 1) + W'(char_code[3:0]);

	assign in_stall     = (state_q != ST_IDLE);
	assign in_acc       = in_valid && !in_stall;
	assign out_valid    = out_valid_q;
	assign result_value = result_value_q;
	assign div_error    = div_error_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			pend_q         <= iee_pkg::OP_START;
			kind_q         <= iee_pkg::KIND_END;
			acc_q          <= '0;
			term_q         <= '0;
			sum_q          <= '0;
			neg_q          <= 1'b0;
			err_q          <= 1'b0;
			qneg_q         <= 1'b0;
			a_q            <= '0;
			b_q            <= '0;
			p_q            <= '0;
			cnt_q          <= '0;
			out_valid_q    <= 1'b0;
			result_value_q <= '0;
			div_error_q    <= 1'b0;
		end else begin
			// ST_OUT reloads the output register itself
			if (out_valid_q && !out_stall && state_q != ST_OUT)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (char_code inside {[iee_pkg::CH_ZERO:iee_pkg::CH_NINE]}) begin
							acc_q <= digit_next;
						end else if (char_code != iee_pkg::CH_SPACE) begin
							case (char_code)
								iee_pkg::CH_MUL: kind_q <= iee_pkg::KIND_MUL;
								iee_pkg::CH_DIV: kind_q <= iee_pkg::KIND_DIV;
								iee_pkg::CH_ADD: kind_q <= iee_pkg::KIND_ADD;
								iee_pkg::CH_SUB: kind_q <= iee_pkg::KIND_SUB;
								default:         kind_q <= iee_pkg::KIND_END;
							endcase
							state_q <= ST_CLOSE;
						end
					end
				end
				ST_CLOSE: begin
					case (pend_q)
						iee_pkg::OP_MUL: begin
							a_q     <= term_q;
							b_q     <= acc_q;
							p_q     <= '0;
							cnt_q   <= '0;
							state_q <= ST_MUL;
						end
						iee_pkg::OP_DIV: begin
							b_q     <= alu_y[W-1:0];  // |dividend|
							state_q <= ST_DIVB;
						end
						default: begin
							term_q  <= acc_q;
							state_q <= ST_TERM;
						end
					endcase
				end
				ST_DIVB: begin
					a_q    <= alu_y[W-1:0];           // |divisor|
					p_q    <= '0;
					cnt_q  <= '0;
					qneg_q <= term_q[W-1] ^ acc_q[W-1];
					if (acc_q == '0) begin
						term_q  <= '0;
						err_q   <= 1'b1;
						state_q <= ST_TERM;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_MUL: begin
					if (b_q[0])
						p_q <= alu_y[W-1:0];
					a_q   <= a_q << 1;
					b_q   <= b_q >> 1;
					cnt_q <= cnt_q + CW'(1);
					if (last_step)
						state_q <= ST_FIX;
				end
				ST_DIV: begin
					// carry out set means the trial subtract did not borrow
					p_q   <= alu_y[W] ? alu_y[W-1:0] : rem_sh;
					b_q   <= {b_q[W-2:0], alu_y[W]};
					cnt_q <= cnt_q + CW'(1);
					if (last_step)
						state_q <= ST_FIX;
				end
				ST_FIX: begin
					if (pend_q == iee_pkg::OP_MUL)
						term_q <= p_q;
					else
						term_q <= alu_y[W-1:0];
					state_q <= ST_TERM;
				end
				ST_TERM: begin
					acc_q <= '0;
					case (kind_q)
						iee_pkg::KIND_MUL: begin
							pend_q  <= iee_pkg::OP_MUL;
							state_q <= ST_IDLE;
						end
						iee_pkg::KIND_DIV: begin
							pend_q  <= iee_pkg::OP_DIV;
							state_q <= ST_IDLE;
						end
						iee_pkg::KIND_ADD, iee_pkg::KIND_SUB: begin
							sum_q   <= alu_y[W-1:0];
							term_q  <= '0;
							neg_q   <= (kind_q == iee_pkg::KIND_SUB);
							pend_q  <= iee_pkg::OP_START;
							state_q <= ST_IDLE;
						end
						default: begin
							sum_q   <= alu_y[W-1:0];
							term_q  <= '0;
							state_q <= ST_OUT;
						end
					endcase
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						result_value_q <= 32'($signed(sum_q));
						div_error_q    <= err_q;
						out_valid_q    <= 1'b1;
						acc_q          <= '0;
						term_q         <= '0;
						sum_q          <= '0;
						pend_q         <= iee_pkg::OP_START;
						neg_q          <= 1'b0;
						err_q          <= 1'b0;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
